// ----- sv/cqe_pkg.sv -----
// ----------------------------------------------------------------------------
// cqe_pkg
// shared types and constants of the cubic quadrature engine
// ----------------------------------------------------------------------------
package cqe_pkg;

    localparam int CQE_MAX_SUBINTERVALS = 1024;
    localparam int CQE_DIV_W            = 41;
    localparam int CQE_N_W              = 11;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_N_ZERO = 2'd1,
        ERR_N_ODD  = 2'd2,
        ERR_N_MOD3 = 2'd3
    } cqe_err_t;

    typedef enum logic [1:0] {
        RULE_TRAP  = 2'd0,
        RULE_S13   = 2'd1,
        RULE_S38   = 2'd2,
        RULE_NONE  = 2'd3
    } cqe_rule_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_H,
        ST_NODES,
        ST_DRAIN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_DIV3_GO,
        ST_DIV3,
        ST_OUTPUT
    } cqe_state_t;

    typedef struct packed {
        logic load;
        logic div_h_start;
        logic node_start;
        logic node_step;
        logic mul_lo;
        logic mul_hi;
        logic scale;
        logic div3_start;
        logic div3_take;
        logic out_load;
    } cqe_cmd_t;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic gen_last;
        logic pipe_empty;
        logic rule_s13;
    } cqe_status_t;

endpackage

// ----- sv/cqe_divider.sv -----
// ----------------------------------------------------------------------------
// cqe_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cqe_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cqe_pkg::CQE_DIV_W-1:0]  dividend,
    input  logic [cqe_pkg::CQE_N_W-1:0]    divisor,
    output logic                           done,
    output logic [cqe_pkg::CQE_DIV_W-1:0]  quotient
);
    import cqe_pkg::*;

    localparam int CNT_W = $clog2(CQE_DIV_W + 1);

    logic [CQE_DIV_W-1:0] dvd_reg, dvd_next;
    logic [CQE_N_W-1:0]   rem_reg, rem_next;
    logic [CQE_N_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CQE_N_W:0]     trial;

    always_comb begin
        trial     = {rem_reg, dvd_reg[CQE_DIV_W-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = CQE_N_W'(trial - {1'b0, dsr_reg});
                dvd_next = {dvd_reg[CQE_DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CQE_N_W-1:0];
                dvd_next = {dvd_reg[CQE_DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CQE_DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- sv/cqe_datapath.sv -----
// ----------------------------------------------------------------------------
// cqe_datapath
// step division, node generator, cubic pipeline, accumulator, scaling, division by three and result register
// ----------------------------------------------------------------------------
module cqe_datapath #(
    parameter int MAX_SUBINTERVALS = cqe_pkg::CQE_MAX_SUBINTERVALS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cqe_pkg::cqe_cmd_t     cmd,
    output cqe_pkg::cqe_status_t  status,
    input  logic [2:0]            s_kind,
    input  logic signed [15:0]    s_lower_limit,
    input  logic signed [15:0]    s_upper_limit,
    input  logic [10:0]           s_subintervals,
    output logic signed [47:0]    m_integral,
    output logic [1:0]            m_error_code
);
    import cqe_pkg::*;

    localparam logic signed [63:0] INT_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] INT_MIN = -64'sd140737488355328;
    localparam int                 D3_W    = 42;

    function automatic logic [1:0] mod3(input logic [10:0] v);
        logic [4:0] t;
        logic [2:0] ev;
        logic [2:0] od;
        ev = 3'(v[0]) + 3'(v[2]) + 3'(v[4]) + 3'(v[6]) + 3'(v[8]) + 3'(v[10]);
        od = 3'(v[1]) + 3'(v[3]) + 3'(v[5]) + 3'(v[7]) + 3'(v[9]);
        t  = 5'(ev) + {1'b0, od, 1'b0};
        if (t >= 5'd9) t = t - 5'd9;
        if (t >= 5'd6) t = t - 5'd6;
        if (t >= 5'd3) t = t - 5'd3;
        return t[1:0];
    endfunction

    // request registers
    cqe_rule_t          rule_reg;
    cqe_err_t           err_reg;
    logic               unused_reg;
    logic [10:0]        n_reg;
    logic signed [15:0] a_reg, b_reg;

    cqe_rule_t   rule_in;
    logic [10:0] n_in;
    cqe_err_t    err_in;

    always_comb begin
        unique case (s_kind)
            3'd0, 3'd3: rule_in = RULE_TRAP;
            3'd1, 3'd4: rule_in = RULE_S13;
            3'd2, 3'd5: rule_in = RULE_S38;
            default:    rule_in = RULE_NONE;
        endcase
        if (s_kind >= 3'd3) begin
            n_in = 11'(rule_in) + 11'd1;
        end else if (32'(s_subintervals) > MAX_SUBINTERVALS) begin
            n_in = 11'(MAX_SUBINTERVALS);
        end else begin
            n_in = s_subintervals;
        end
        if (n_in == '0) begin
            err_in = ERR_N_ZERO;
        end else if (rule_in == RULE_S13 && n_in[0]) begin
            err_in = ERR_N_ODD;
        end else if (rule_in == RULE_S38 && mod3(n_in) != 2'd0) begin
            err_in = ERR_N_MOD3;
        end else begin
            err_in = ERR_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rule_reg   <= rule_in;
            unused_reg <= (s_kind > 3'd5);
            err_reg    <= (s_kind > 3'd5) ? ERR_OK : err_in;
            n_reg      <= n_in;
            a_reg      <= s_lower_limit;
            b_reg      <= s_upper_limit;
        end
    end

    // step division
    logic signed [28:0]    diff;
    logic                  diff_neg;
    logic [CQE_DIV_W-1:0]  div_dividend;
    logic [CQE_N_W-1:0]    div_divisor;
    logic                  div_done;
    logic [CQE_DIV_W-1:0]  div_quot;
    logic signed [63:0]    res_reg;
    logic                  neg_reg;
    logic signed [40:0]    q41;

    assign diff     = {(17'(b_reg) - 17'(a_reg)), 12'b0};
    assign diff_neg = diff[28];
    assign q41      = res_reg[40:0];

    always_comb begin
        div_divisor  = n_reg;
        div_dividend = diff_neg ? CQE_DIV_W'(-diff) : CQE_DIV_W'(diff);
    end

    cqe_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_h_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // division by three, six bits a cycle
    logic [40:0]     d3_dividend;
    logic [D3_W-1:0] d3_val_reg;
    logic [1:0]      d3_rem_reg, d3_rem_next;
    logic [2:0]      d3_cnt_reg;
    logic            d3_busy_reg;
    logic            d3_done_reg;
    logic [5:0]      d3_digit;
    logic [2:0]      t3;

    assign d3_dividend = q41[40] ? 41'(-q41 + 41'sd2) : 41'(q41);

    always_comb begin
        d3_rem_next = d3_rem_reg;
        d3_digit    = '0;
        t3          = '0;
        for (int k = 5; k >= 0; k--) begin
            t3 = {d3_rem_next, d3_val_reg[D3_W-6+k]};
            if (t3 >= 3'd3) begin
                d3_digit[k] = 1'b1;
                d3_rem_next = 2'(t3 - 3'd3);
            end else begin
                d3_digit[k] = 1'b0;
                d3_rem_next = t3[1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d3_busy_reg <= 1'b0;
            d3_done_reg <= 1'b0;
            d3_cnt_reg  <= '0;
        end else begin
            if (cmd.div3_start) begin
                d3_busy_reg <= 1'b1;
                d3_cnt_reg  <= '0;
            end else if (d3_busy_reg) begin
                d3_busy_reg <= (d3_cnt_reg != 3'd6);
                d3_cnt_reg  <= d3_cnt_reg + 3'd1;
            end
            d3_done_reg <= d3_busy_reg && (d3_cnt_reg == 3'd6);
        end
        if (cmd.div3_start) begin
            d3_val_reg <= {1'b0, d3_dividend};
            d3_rem_reg <= '0;
        end else if (d3_busy_reg) begin
            d3_val_reg <= {d3_val_reg[D3_W-7:0], d3_digit};
            d3_rem_reg <= d3_rem_next;
        end
    end

    // node generator
    logic signed [28:0] h_reg;
    logic signed [28:0] a24, b24;
    logic signed [28:0] node_x_reg;
    logic [10:0]        idx_reg;
    logic [1:0]         m3_reg;
    logic [10:0]        node_i;
    logic signed [28:0] emit_x;
    logic [2:0]         emit_w;

    assign a24    = {a_reg[15], a_reg, 12'b0};
    assign b24    = {b_reg[15], b_reg, 12'b0};
    assign node_i = idx_reg - 11'd1;

    always_comb begin
        priority if (idx_reg == 11'd0) begin
            emit_x = a24;
            emit_w = 3'd1;
        end else if (idx_reg == 11'd1) begin
            emit_x = b24;
            emit_w = 3'd1;
        end else begin
            emit_x = node_x_reg;
            unique case (rule_reg)
                RULE_S13: emit_w = node_i[0] ? 3'd4 : 3'd2;
                RULE_S38: emit_w = (m3_reg == 2'd0) ? 3'd2 : 3'd3;
                default:  emit_w = 3'd2;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.node_start) begin
            h_reg      <= neg_reg ? -29'(div_quot) : 29'(div_quot);
            idx_reg    <= '0;
            node_x_reg <= a24;
            m3_reg     <= '0;
        end else if (cmd.node_step) begin
            idx_reg <= idx_reg + 11'd1;
            if (idx_reg != 11'd0) begin
                node_x_reg <= node_x_reg + h_reg;
            end
            if (idx_reg == 11'd1) begin
                m3_reg <= 2'd1;
            end else if (idx_reg != 11'd0) begin
                m3_reg <= (m3_reg == 2'd2) ? 2'd0 : m3_reg + 2'd1;
            end
        end
    end

    // cubic pipeline
    logic               v0_reg, v1_reg, v2_reg;
    logic signed [28:0] x0_reg, x1_reg;
    logic [2:0]         w0_reg, w1_reg, w2_reg;
    logic [30:0]        sq_reg;
    logic signed [29:0] f_reg;
    logic signed [57:0] xx;
    logic signed [60:0] sqx;
    logic signed [32:0] wf;
    logic signed [43:0] acc_reg;

    assign xx  = x0_reg * x0_reg;
    assign sqx = $signed({1'b0, sq_reg}) * x1_reg;

    always_comb begin
        unique case (w2_reg)
            3'd1:    wf = 33'(f_reg);
            3'd2:    wf = 33'(f_reg) <<< 1;
            3'd3:    wf = 33'(f_reg) + (33'(f_reg) <<< 1);
            default: wf = 33'(f_reg) <<< 2;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= cmd.node_step;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
        x0_reg <= emit_x;
        w0_reg <= emit_w;
        sq_reg <= 31'(xx >>> 24);
        x1_reg <= x0_reg;
        w1_reg <= w0_reg;
        f_reg  <= 30'sd65536 + 30'(sqx >>> 32);
        w2_reg <= w1_reg;
        if (cmd.node_start) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + 44'(wf);
        end
    end

    // final scaling
    logic signed [50:0] p_lo;
    logic signed [50:0] p_hi;
    logic signed [63:0] prod_reg;
    logic signed [63:0] p3;

    assign p_lo = $signed({1'b0, acc_reg[21:0]}) * h_reg;
    assign p_hi = $signed(acc_reg[43:22]) * h_reg;
    assign p3   = prod_reg + (prod_reg <<< 1);

    always_ff @(posedge aclk) begin
        if (cmd.div_h_start) begin
            neg_reg <= diff_neg;
        end else if (cmd.div3_start) begin
            neg_reg <= q41[40];
        end
        if (cmd.mul_lo) begin
            prod_reg <= 64'(p_lo);
        end else if (cmd.mul_hi) begin
            prod_reg <= prod_reg + (64'(p_hi) <<< 22);
        end
        if (cmd.scale) begin
            unique case (rule_reg)
                RULE_S13: res_reg <= prod_reg >>> 24;
                RULE_S38: res_reg <= p3 >>> 27;
                default:  res_reg <= prod_reg >>> 25;
            endcase
        end else if (cmd.div3_take) begin
            res_reg <= neg_reg ? -64'(d3_val_reg) : 64'(d3_val_reg);
        end
    end

    // result register
    logic signed [47:0] integral_reg;
    logic [1:0]         code_reg;
    logic signed [47:0] sat;

    always_comb begin
        priority if (res_reg > INT_MAX) begin
            sat = 48'(INT_MAX);
        end else if (res_reg < INT_MIN) begin
            sat = 48'(INT_MIN);
        end else begin
            sat = res_reg[47:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            integral_reg <= status.bad ? '0 : sat;
            code_reg     <= err_reg;
        end
    end

    assign m_integral        = integral_reg;
    assign m_error_code      = code_reg;
    assign status.bad        = unused_reg || (err_reg != ERR_OK);
    assign status.div_done   = div_done || d3_done_reg;
    assign status.gen_last   = (idx_reg == n_reg);
    assign status.pipe_empty = !v0_reg && !v1_reg && !v2_reg;
    assign status.rule_s13   = (rule_reg == RULE_S13);

endmodule

// ----- sv/cqe_controller.sv -----
// ----------------------------------------------------------------------------
// cqe_controller
// sequencer of the quadrature engine and its request handshakes
// ----------------------------------------------------------------------------
module cqe_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  cqe_pkg::cqe_status_t status,
    output cqe_pkg::cqe_cmd_t    cmd
);
    import cqe_pkg::*;

    cqe_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_CHECK;
            ST_CHECK:   state_next = status.bad ? ST_OUTPUT : ST_DIV_H;
            ST_DIV_H:   if (status.div_done) state_next = ST_NODES;
            ST_NODES:   if (status.gen_last) state_next = ST_DRAIN;
            ST_DRAIN:   if (status.pipe_empty) state_next = ST_MUL_LO;
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_SCALE;
            ST_SCALE:   state_next = status.rule_s13 ? ST_DIV3_GO : ST_OUTPUT;
            ST_DIV3_GO: state_next = ST_DIV3;
            ST_DIV3:    if (status.div_done) state_next = ST_OUTPUT;
            ST_OUTPUT:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.load        = (state_reg == ST_IDLE) && s_valid;
        cmd.div_h_start = (state_reg == ST_CHECK) && !status.bad;
        cmd.node_start  = (state_reg == ST_DIV_H) && status.div_done;
        cmd.node_step   = (state_reg == ST_NODES);
        cmd.mul_lo      = (state_reg == ST_MUL_LO);
        cmd.mul_hi      = (state_reg == ST_MUL_HI);
        cmd.scale       = (state_reg == ST_SCALE);
        cmd.div3_start  = (state_reg == ST_DIV3_GO);
        cmd.div3_take   = (state_reg == ST_DIV3) && status.div_done;
        cmd.out_load    = (state_reg == ST_OUTPUT) && out_free;
        s_ready         = (state_reg == ST_IDLE);
        m_valid_next    = cmd.out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- sv/cubic_quadrature_engine.sv -----
// ----------------------------------------------------------------------------
// cubic_quadrature_engine
// composite newton-cotes integration of 1 + x^3 over [a, b]
// ----------------------------------------------------------------------------
// One request at a time. A valid request is checked, then the bit-serial
// divider finds the 41 quotient bits of h = (b-a)/n, the nodes are fed to
// the cubic pipeline (one node per cycle, both ends included), the pipeline
// drains, the sum is multiplied and scaled and the output register is loaded.
// Simpson 1/3 adds a division by three, six bits a cycle. A rejected request
// goes from the check straight to loading the output register. The next
// request can be taken in the cycle after the result is loaded, while that
// result waits in the output register; a result still waiting when the next
// one is done holds the engine.
// ----------------------------------------------------------------------------
module cubic_quadrature_engine #(
    parameter int MAX_SUBINTERVALS = cqe_pkg::CQE_MAX_SUBINTERVALS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_kind,
    input  logic signed [15:0] s_lower_limit,
    input  logic signed [15:0] s_upper_limit,
    input  logic [10:0]        s_subintervals,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_integral,
    output logic [1:0]         m_error_code
);
    import cqe_pkg::*;

    cqe_cmd_t    cmd;
    cqe_status_t status;

    cqe_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cqe_datapath #(
        .MAX_SUBINTERVALS (MAX_SUBINTERVALS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_kind         (s_kind),
        .s_lower_limit  (s_lower_limit),
        .s_upper_limit  (s_upper_limit),
        .s_subintervals (s_subintervals),
        .m_integral     (m_integral),
        .m_error_code   (m_error_code)
    );

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code != ERR_OK) |-> (m_integral == '0))
        else $error("error result with nonzero integral");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten");
`endif

endmodule
